// ===== src/rgb_3x3_convolution_clamped_defines.svh =====
// assertion macros for the rgb 3x3 convolution block
`ifndef RGB_3X3_CONVOLUTION_CLAMPED_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_CLAMPED_DEFINES_SVH
`ifndef SYNTHESIS
`define RGBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("rgbc assertion failed");
`define RGBC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("rgbc assertion failed");
`else
`define RGBC_ASSERT(lbl, clk, rst_n, prop)
`define RGBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/rgbc_pkg.sv =====
// shared types, register indexes and helpers of the rgb 3x3 convolution
`timescale 1ns / 1ps
`default_nettype none
package rgbc_pkg;
	typedef logic [23:0] pixel_t;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KTOP   = 3'd2,
		REG_KMID   = 3'd3,
		REG_KBOT   = 3'd4
	} reg_idx_t;

	// signed coefficient j (0 = left) of a kernel row word
	function automatic logic signed [7:0] coef_of(input logic [23:0] w, input logic [1:0] j);
		logic [7:0] b;
		case (j)
			2'd0: b = w[7:0];
			2'd1: b = w[15:8];
			2'd2: b = w[23:16];
			default: b = 8'd0;
		endcase
		return $signed(b);
	endfunction
endpackage
`default_nettype wire

// ===== src/rgbc_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rgbc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/rgbc_cell.sv =====
// one window column cell: three pixels, shifted to the left neighbor
`timescale 1ns / 1ps
`default_nettype none
module rgbc_cell import rgbc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   shift,
	input  wire pixel_t in_px [3],
	output pixel_t      col_px [3]
);
	always_ff @(posedge clk) begin
		if (shift) begin
			col_px <= in_px;
		end
	end
endmodule
`default_nettype wire

// ===== src/rgb_3x3_convolution_clamped.sv =====
// top level of the streaming rgb 3x3 convolution with clamping
// usage:
//  pixels come in raster order on red/green/blue with in_valid/in_ready;
//  each request is one pixel. results leave on out_valid/out_ready with
//  their row and column; run_last marks the last result of a pixel.
//  a pixel causes 0 to 4 results, each given once its last neighbour is in.
//  configuration: cfg_we/cfg_index/cfg_data, written only while idle.
// throughput: one pixel per cycle while each pixel causes at most one
//  result and the output is not stalled; a pixel with more results holds
//  the window, since the single shared tap/multiply/sum pipe emits one
//  result per cycle unless stalled. pipeline: accept with line store
//  read -> window -> taps -> products -> clamped output register.
// reset: counters, valid bits and pending results clear; line stores and
//  window are not cleared, they are always written before a legal read.
// stall: with out_valid high and out_ready low the whole pipe freezes;
//  in_ready drops when stage 1 cannot move; the output keeps its result.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_3x3_convolution_clamped_defines.svh"
module rgb_3x3_convolution_clamped import rgbc_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [23:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    red,
	input  wire logic [7:0]                    green,
	input  wire logic [7:0]                    blue,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [$clog2(MAX_HEIGHT)-1:0] out_row,
	output logic      [$clog2(MAX_WIDTH)-1:0]  out_col,
	output logic      [7:0]                    out_red,
	output logic      [7:0]                    out_green,
	output logic      [7:0]                    out_blue,
	output logic                               run_last
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// configuration registers
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [23:0] ktop_q, kmid_q, kbot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			ktop_q   <= 24'd0;
			kmid_q   <= 24'd256;
			kbot_q   <= 24'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_KTOP:   ktop_q   <= cfg_data;
				REG_KMID:   kmid_q   <= cfg_data;
				REG_KBOT:   kbot_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// last column and last row of the effective frame size
	logic [CW-1:0] wl;
	logic [RW-1:0] hl;
	always_comb begin
		if (width_q == 11'd0) begin
			wl = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			wl = CW'(MAX_WIDTH - 1);
		end else begin
			wl = CW'(width_q - 11'd1);
		end
		if (height_q == 13'd0) begin
			hl = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			hl = RW'(MAX_HEIGHT - 1);
		end else begin
			hl = RW'(height_q - 13'd1);
		end
	end

	// pipeline control
	logic       en;        // downstream pipe moves
	logic       in_fire;
	logic       s1_go;     // item enters the window
	logic       emit_fire; // one result issued into the tap stage
	logic [3:0] pend_q;    // results still to issue for the window item
	logic [3:0] pick;
	logic       s1_v_q;

	assign en        = !out_valid || out_ready;
	assign pick      = pend_q & (~pend_q + 4'd1);
	assign emit_fire = (pend_q != 4'd0) && en;
	assign s1_go     = s1_v_q && en && ((pend_q & ~pick) == 4'd0);
	assign in_ready  = !s1_v_q || s1_go;
	assign in_fire   = in_valid && in_ready;

	// position counters, clipped to the frame after a size change
	logic [CW-1:0] col_q, cu;
	logic [RW-1:0] row_q, ru;
	logic          last_c, last_r;
	assign cu     = (col_q <= wl) ? col_q : wl;
	assign ru     = (row_q <= hl) ? row_q : hl;
	assign last_c = (cu == wl);
	assign last_r = (ru == hl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= last_r ? '0 : ru + RW'(1);
			end else begin
				col_q <= cu + CW'(1);
				row_q <= ru;
			end
		end
	end

	// stage 1: line store read
	pixel_t        px_s1, fwd_prev_s1, fwd_prev2_s1;
	logic [CW-1:0] cu_s1;
	logic [RW-1:0] ru_s1;
	logic [3:0]    mask_s1;
	logic          fwd_s1;
	pixel_t        prev_rd, prev2_rd, above, above2;

	assign above  = fwd_s1 ? fwd_prev_s1  : prev_rd;
	assign above2 = fwd_s1 ? fwd_prev2_s1 : prev2_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ready) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1 <= {blue, green, red};
			cu_s1 <= cu;
			ru_s1 <= ru;
			mask_s1 <= {last_r & last_c, last_r & (cu != '0),
				(ru != '0) & last_c, (ru != '0) & (cu != '0)};
			// same column written while read: take the write data instead
			fwd_s1       <= s1_go && (cu_s1 == cu);
			fwd_prev_s1  <= px_s1;
			fwd_prev2_s1 <= above;
		end
	end

	rgbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_prev (
		.clk(clk), .we(s1_go), .waddr(cu_s1), .wdata(px_s1),
		.re(in_fire), .raddr(cu), .rdata(prev_rd)
	);
	rgbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_prev2 (
		.clk(clk), .we(s1_go), .waddr(cu_s1), .wdata(above),
		.re(in_fire), .raddr(cu), .rdata(prev2_rd)
	);

	// window: chain of three column cells, newest column at cell 2
	pixel_t col_new [3];
	pixel_t col0 [3], col1 [3], col2 [3];
	assign col_new[0] = above2;
	assign col_new[1] = above;
	assign col_new[2] = px_s1;

	rgbc_cell u_cell2 (.clk(clk), .shift(s1_go), .in_px(col_new), .col_px(col2));
	rgbc_cell u_cell1 (.clk(clk), .shift(s1_go), .in_px(col2), .col_px(col1));
	rgbc_cell u_cell0 (.clk(clk), .shift(s1_go), .in_px(col1), .col_px(col0));

	logic [CW-1:0] wc_q;
	logic [RW-1:0] wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else if (s1_go) begin
			pend_q <= mask_s1;
		end else if (emit_fire) begin
			pend_q <= pend_q & ~pick;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			wc_q <= cu_s1;
			wr_q <= ru_s1;
		end
	end

	// tap selection for the picked result
	pixel_t        win [9];
	pixel_t        centre;
	pixel_t        taps [9];
	logic          rsel, csel;
	logic [RW-1:0] rc;
	logic [CW-1:0] cc;
	logic [2:0]    row_ok, col_ok;

	always_comb begin
		logic [1:0] ri, ci;
		for (int r = 0; r < 3; r++) begin
			win[r*3]     = col0[r];
			win[r*3 + 1] = col1[r];
			win[r*3 + 2] = col2[r];
		end
		rsel = pick[2] | pick[3];
		csel = pick[1] | pick[3];
		rc   = rsel ? wr_q : wr_q - RW'(1);
		cc   = csel ? wc_q : wc_q - CW'(1);
		centre = win[{2'b0, rsel} * 3 + {2'b0, csel} + 1 + 3];
		row_ok = {rc != hl, 1'b1, rc != '0};
		col_ok = {cc != wl, 1'b1, cc != '0};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ri = 2'(i) + {1'b0, rsel};
				ci = 2'(j) + {1'b0, csel};
				if (row_ok[i] && col_ok[j] && ri != 2'd3 && ci != 2'd3) begin
					taps[i*3 + j] = win[ri * 3 + ci];
				end else begin
					taps[i*3 + j] = centre;
				end
			end
		end
	end

	// stage e1: taps registered
	pixel_t        taps_s1 [9];
	logic [RW-1:0] rc_s1;
	logic [CW-1:0] cc_s1;
	logic          last_s1, e1_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_v_q <= 1'b0;
		end else if (en) begin
			e1_v_q <= emit_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			taps_s1 <= taps;
			rc_s1   <= rc;
			cc_s1   <= cc;
			last_s1 <= ((pend_q & ~pick) == 4'd0);
		end
	end

	// stage e2: products, 8-bit pixel times signed 8-bit coefficient
	logic signed [16:0] prod [3][9];
	logic signed [16:0] prod_s2 [3][9];
	logic [RW-1:0]      rc_s2;
	logic [CW-1:0]      cc_s2;
	logic               last_s2, e2_v_q;

	always_comb begin
		logic signed [7:0]  k;
		logic        [23:0] kw;
		for (int t = 0; t < 9; t++) begin
			kw = (t < 3) ? ktop_q : ((t < 6) ? kmid_q : kbot_q);
			k  = coef_of(kw, 2'(t % 3));
			for (int ch = 0; ch < 3; ch++) begin
				prod[ch][t] = $signed({1'b0, taps_s1[t][ch*8 +: 8]}) * k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e2_v_q <= 1'b0;
		end else if (en) begin
			e2_v_q <= e1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && e1_v_q) begin
			prod_s2 <= prod;
			rc_s2   <= rc_s1;
			cc_s2   <= cc_s1;
			last_s2 <= last_s1;
		end
	end

	// stage e3: nine-term sums, clamp, output register
	logic [7:0] clamped [3];

	always_comb begin
		logic signed [20:0] acc;
		for (int ch = 0; ch < 3; ch++) begin
			acc = '0;
			for (int t = 0; t < 9; t++) begin
				acc = acc + 21'(prod_s2[ch][t]);
			end
			if (acc < 0) begin
				clamped[ch] = 8'd0;
			end else if (acc > 21'sd255) begin
				clamped[ch] = 8'd255;
			end else begin
				clamped[ch] = acc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= e2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && e2_v_q) begin
			out_row   <= rc_s2;
			out_col   <= cc_s2;
			out_red   <= clamped[0];
			out_green <= clamped[1];
			out_blue  <= clamped[2];
			run_last  <= last_s2;
		end
	end

	// a window item is only replaced once its results are all issued
	`RGBC_ASSERT(a_go_drains, clk, arst_n, s1_go |-> ((pend_q & ~pick) == 4'd0))
	// the issue pick is a single result whenever one is pending
	`RGBC_ASSERT(a_pick_one, clk, arst_n, (pend_q != 4'd0) |-> $onehot(pick))
	// a stalled tap stage keeps its result
	`RGBC_ASSERT(a_e1_hold, clk, arst_n, (e1_v_q && !en) |=> e1_v_q)
endmodule
`default_nettype wire

// ===== test/rgb_3x3_convolution_clamped_tb.sv =====
// self-checking testbench of the streaming rgb 3x3 convolution with clamping
`timescale 1ns / 1ps
module rgb_3x3_convolution_clamped_tb;
	import rgbc_pkg::*;

	// index with no register behind it, writes to it must change nothing
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;
	// leave margin for the pipe to drain before touching registers
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [11:0] row;
		logic [9:0]  col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} filtered_px_t;

	// one row of the directed part: a register write or a pixel
	typedef struct {
		bit           is_cfg;
		logic [2:0]   idx;
		logic [23:0]  data;
		logic [7:0]   r, g, b;
		bit           typed;
		filtered_px_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [7:0] red, green, blue;
	logic out_valid;
	logic out_ready;
	logic [11:0] out_row;
	logic [9:0] out_col;
	logic [7:0] out_red, out_green, out_blue;
	logic run_last;

	rgb_3x3_convolution_clamped uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_row(out_row), .out_col(out_col),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.run_last(run_last)
	);

	// shadow of the registers, raw as written
	logic [10:0] sh_width;
	logic [12:0] sh_height;
	logic [23:0] sh_ktop, sh_kmid, sh_kbot;
	// shadow of the stream position, line stores and window
	int col_pos, row_pos;
	pixel_t prev_line [MAX_W];
	pixel_t prev2_line [MAX_W];
	pixel_t win [3][3];

	filtered_px_t pending_px [$];
	int n_errors;
	int n_pixels;
	int n_results;
	int n_frames;
	// sender asks the receiver for one long hold-off
	bit hold_req;
	bit no_gap;
	bit burst;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] sat8(input int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// one filtered pixel at (rc, cc) while the window ends at (rr, cr)
	function automatic filtered_px_t filter_at(input int rc, input int cc, input int rr,
			input int cr, input int w, input int h);
		int wr0, wc0, y, x, k, sr, sg, sb;
		pixel_t centre, p;
		logic [23:0] kw;
		filtered_px_t f;
		wr0 = rc - (rr - 2);
		wc0 = cc - (cr - 2);
		centre = win[wr0][wc0];
		sr = 0;
		sg = 0;
		sb = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			kw = (dy < 0) ? sh_ktop : ((dy == 0) ? sh_kmid : sh_kbot);
			for (int dx = -1; dx <= 1; dx++) begin
				y = rc + dy;
				x = cc + dx;
				k = int'($signed(kw[8*(dx+1) +: 8]));
				p = centre;
				// taps off the image take the centre pixel
				if (y >= 0 && y < h && x >= 0 && x < w && wr0 + dy >= 0 && wr0 + dy < 3
						&& wc0 + dx >= 0 && wc0 + dx < 3)
					p = win[wr0+dy][wc0+dx];
				sr += int'(p[7:0]) * k;
				sg += int'(p[15:8]) * k;
				sb += int'(p[23:16]) * k;
			end
		end
		f.row = rc[11:0];
		f.col = cc[9:0];
		f.red = sat8(sr);
		f.green = sat8(sg);
		f.blue = sat8(sb);
		f.last = 1'b0;
		return f;
	endfunction

	// advance the shadow by one pixel and return the pixels it completes
	function automatic void convolve_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, output filtered_px_t res[$]);
		int w, h, cu, ru;
		pixel_t px, above, above2;
		res = {};
		w = (sh_width == 0) ? 1 : ((sh_width > MAX_W) ? MAX_W : int'(sh_width));
		h = (sh_height == 0) ? 1 : ((sh_height > MAX_H) ? MAX_H : int'(sh_height));
		cu = (col_pos < w) ? col_pos : w - 1;
		ru = (row_pos < h) ? row_pos : h - 1;
		px = {b, g, r};
		above = prev_line[cu];
		above2 = prev2_line[cu];
		prev2_line[cu] = above;
		prev_line[cu] = px;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = above2;
		win[1][2] = above;
		win[2][2] = px;
		// up to four neighbours become complete, in raster order
		if (ru >= 1 && cu >= 1) res.push_back(filter_at(ru - 1, cu - 1, ru, cu, w, h));
		if (ru >= 1 && cu == w - 1) res.push_back(filter_at(ru - 1, cu, ru, cu, w, h));
		if (ru == h - 1 && cu >= 1) res.push_back(filter_at(ru, cu - 1, ru, cu, w, h));
		if (ru == h - 1 && cu == w - 1) res.push_back(filter_at(ru, cu, ru, cu, w, h));
		if (res.size() > 0) res[res.size()-1].last = 1'b1;
		if (cu == w - 1) begin
			col_pos = 0;
			row_pos = (ru == h - 1) ? 0 : ru + 1;
		end else begin
			col_pos = cu + 1;
			row_pos = ru;
		end
	endfunction

	// stop offering, wait for every expected pixel, then let the pipe drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_WIDTH: sh_width = data[10:0];
			REG_HEIGHT: sh_height = data[12:0];
			REG_KTOP: sh_ktop = data;
			REG_KMID: sh_kmid = data;
			REG_KBOT: sh_kbot = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one pixel, hold it until taken, then book its expectations
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input bit typed, input filtered_px_t want);
		int gap;
		filtered_px_t res[$];
		gap = (no_gap || burst) ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		red <= r;
		green <= g;
		blue <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		convolve_pixel(r, g, b, res);
		n_pixels++;
		if (typed) pending_px.push_back(want);
		else foreach (res[i]) pending_px.push_back(res[i]);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly small coefficients so sums often land inside 0..255
	function automatic logic [23:0] rand_kernel_row();
		logic [23:0] kw;
		for (int j = 0; j < 3; j++)
			kw[8*j +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
				: 8'($urandom_range(0, 24) - 8);
		return kw;
	endfunction

	// one whole frame of random pixels, registers written while idle
	task automatic run_frame(input logic [10:0] w, input logic [12:0] h, input bit rand_k,
			input bit hold);
		int npx;
		filtered_px_t none;
		none = '0;
		wait_idle();
		write_reg(REG_WIDTH, 24'(w));
		write_reg(REG_HEIGHT, 24'(h));
		if (rand_k) begin
			write_reg(REG_KTOP, rand_kernel_row());
			write_reg(REG_KMID, rand_kernel_row());
			write_reg(REG_KBOT, rand_kernel_row());
		end
		npx = ((w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w))
			* ((h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h));
		burst = ($urandom_range(0, 3) == 0);
		if (hold) begin
			// receiver stalls long while pixels keep coming back to back
			no_gap = 1'b1;
			hold_req = 1'b1;
		end
		repeat (npx) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, none);
		no_gap = 1'b0;
		burst = 1'b0;
		n_frames++;
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				n = 300;
				hold_req = 1'b0;
			end else begin
				n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// result checker
	always @(posedge clk) begin
		filtered_px_t w;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_px.size() == 0) begin
				$error("unexpected result at row %0d col %0d", out_row, out_col);
				n_errors++;
			end else begin
				w = pending_px.pop_front();
				if (out_row !== w.row) begin
					$error("out_row expected %0d got %0d", w.row, out_row);
					n_errors++;
				end
				if (out_col !== w.col) begin
					$error("out_col expected %0d got %0d", w.col, out_col);
					n_errors++;
				end
				if (out_red !== w.red) begin
					$error("out_red expected %0d got %0d", w.red, out_red);
					n_errors++;
				end
				if (out_green !== w.green) begin
					$error("out_green expected %0d got %0d", w.green, out_green);
					n_errors++;
				end
				if (out_blue !== w.blue) begin
					$error("out_blue expected %0d got %0d", w.blue, out_blue);
					n_errors++;
				end
				if (run_last !== w.last) begin
					$error("run_last expected %0d got %0d", w.last, run_last);
					n_errors++;
				end
			end
		end
	end

	// main stimulus
	initial begin
		stim_row_t tbl[$];
		int n_rand;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		hold_req = 1'b0;
		no_gap = 1'b0;
		burst = 1'b0;
		n_errors = 0;
		n_pixels = 0;
		n_results = 0;
		n_frames = 0;
		sh_width = 11'd1024;
		sh_height = 13'd1024;
		sh_ktop = 24'h0;
		sh_kmid = 24'h000100;
		sh_kbot = 24'h0;
		col_pos = 0;
		row_pos = 0;
		foreach (prev_line[i]) begin
			prev_line[i] = '0;
			prev2_line[i] = '0;
		end
		foreach (win[i, j]) win[i][j] = '0;

		// directed: 1x1 frames with reset identity kernel, then extreme kernels
		tbl.push_back('{1, REG_WIDTH, 24'd1, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_HEIGHT, 24'd1, 0, 0, 0, 0, '0});
		tbl.push_back('{0, 0, 0, 8'd0, 8'd0, 8'd0, 1, '{0, 0, 8'd0, 8'd0, 8'd0, 1}});
		tbl.push_back('{0, 0, 0, 8'd255, 8'd255, 8'd255, 1,
			'{0, 0, 8'd255, 8'd255, 8'd255, 1}});
		tbl.push_back('{0, 0, 0, 8'd1, 8'd128, 8'd254, 1,
			'{0, 0, 8'd1, 8'd128, 8'd254, 1}});
		// write to an index with no register is ignored
		tbl.push_back('{1, REG_UNUSED, 24'hFFFFFF, 0, 0, 0, 0, '0});
		tbl.push_back('{0, 0, 0, 8'd7, 8'd8, 8'd9, 1, '{0, 0, 8'd7, 8'd8, 8'd9, 1}});
		// all coefficients at the positive extreme: any nonzero channel saturates
		tbl.push_back('{1, REG_KTOP, 24'h7F7F7F, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KMID, 24'h7F7F7F, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KBOT, 24'h7F7F7F, 0, 0, 0, 0, '0});
		tbl.push_back('{0, 0, 0, 8'd1, 8'd0, 8'd200, 1, '{0, 0, 8'd255, 8'd0, 8'd255, 1}});
		// all at the negative extreme: clamps to zero
		tbl.push_back('{1, REG_KTOP, 24'h808080, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KMID, 24'h808080, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KBOT, 24'h808080, 0, 0, 0, 0, '0});
		tbl.push_back('{0, 0, 0, 8'd255, 8'd255, 8'd255, 1, '{0, 0, 8'd0, 8'd0, 8'd0, 1}});
		// 3x3 frame with a sharpening kernel, checked against the shadow model
		tbl.push_back('{1, REG_WIDTH, 24'd3, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_HEIGHT, 24'd3, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KTOP, 24'h00FF00, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KMID, 24'hFF05FF, 0, 0, 0, 0, '0});
		tbl.push_back('{1, REG_KBOT, 24'h00FF00, 0, 0, 0, 0, '0});
		for (int i = 0; i < 9; i++)
			tbl.push_back('{0, 0, 0, rand_chan(), rand_chan(), rand_chan(), 0, '0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (tbl[i]) begin
			if (tbl[i].is_cfg) begin
				wait_idle();
				write_reg(tbl[i].idx, tbl[i].data);
			end else begin
				send_pixel(tbl[i].r, tbl[i].g, tbl[i].b, tbl[i].typed, tbl[i].want);
			end
		end

		// size extremes: zero sizes act as one, single rows and columns
		run_frame(11'd0, 13'd0, 1, 0);
		run_frame(11'd1, 13'd4, 1, 0);
		run_frame(11'd4, 13'd1, 1, 0);
		// back-pressure: long receiver stall against a full-rate sender
		run_frame(11'd8, 13'd6, 1, 1);

		n_rand = 0;
		while (n_rand < 290) begin
			int w, h;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			run_frame(11'(w), 13'(h), 1, 0);
			n_rand += w * h;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_idle();

		$display("covered %0d frames, %0d pixels in, %0d filtered pixels out",
			n_frames, n_pixels, n_results);
		$display("sizes from zero and 1x1 up to 12x8, extreme and random kernels");
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
